// ===== hw/rtl/prrs_pkg.sv =====
`timescale 1ns / 1ps

package prrs_pkg;

    localparam int SLOT_W  = 3;
    localparam int COUNT_W = 4;
    localparam int PRIO_W  = 8;
    localparam int MASK_W  = 8;
    localparam int REQ_W   = 2;
    localparam int DELAY_W = 32;
    localparam int TICKO_W = 32;
    localparam int CFG_W   = 64;

    localparam logic [PRIO_W-1:0] NO_PRIO = 8'hFF;

    // request kinds carried on s_tuser
    localparam logic [REQ_W-1:0] REQ_TICK  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DELAY = 2'd1;
    localparam logic [REQ_W-1:0] REQ_YIELD = 2'd2;

    // configuration register indexes
    localparam logic REG_TASK_COUNT = 1'b0;
    localparam logic REG_TASK_PRIO  = 1'b1;

    typedef enum logic [1:0] {
        SLOT_READY   = 2'd0,
        SLOT_RUNNING = 2'd1,
        SLOT_BLOCKED = 2'd2
    } slot_st_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_WAKE,
        OP_BLOCK,
        OP_RELEASE,
        OP_SELECT
    } cell_op_t;

    // command broadcast to every cell
    typedef struct packed {
        cell_op_t             op;
        logic [SLOT_W-1:0]    cur;
        logic [SLOT_W-1:0]    sel;
        logic [COUNT_W-1:0]   n;
    } cell_cmd_t;

    // best candidate so far, handed down the chain
    typedef struct packed {
        logic                 found;
        logic [PRIO_W-1:0]    prio;
        logic [SLOT_W-1:0]    gap;
        logic [SLOT_W-1:0]    idx;
    } cand_t;

endpackage

// ===== hw/rtl/prrs_cell.sv =====
`timescale 1ns / 1ps

module prrs_cell #(
    parameter int SLOT_IDX   = 0,
    parameter int MAX_TASKS  = 8,
    parameter int TICK_WIDTH = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  prrs_pkg::cell_cmd_t          cmd,
    input  logic [TICK_WIDTH-1:0]        counter,
    input  logic [TICK_WIDTH-1:0]        block_wake,
    input  logic [prrs_pkg::PRIO_W-1:0]  prio,
    input  prrs_pkg::cand_t              cand_in,
    output prrs_pkg::cand_t              cand_out,
    output logic                         slot_ready
);
    import prrs_pkg::*;

    localparam logic [SLOT_W-1:0] MY_IDX = SLOT_W'(SLOT_IDX);

    slot_st_t               state_reg, state_next;
    logic [TICK_WIDTH-1:0]  wake_reg, wake_next;
    cand_t                  cand_reg, cand_next;

    logic                   in_use;
    logic                   is_cur;
    logic [TICK_WIDTH-1:0]  diff;
    logic                   due;
    logic [SLOT_W:0]        gap_full;
    logic [SLOT_W-1:0]      gap;
    logic                   eligible;
    logic                   better;

    assign in_use = COUNT_W'(SLOT_IDX) < cmd.n;
    assign is_cur = cmd.cur == MY_IDX;
    assign diff   = counter - wake_reg;
    assign due    = !diff[TICK_WIDTH-1];

    always_comb begin
        state_next = state_reg;
        wake_next  = wake_reg;
        unique case (cmd.op)
            OP_WAKE: begin
                if (in_use && state_reg == SLOT_BLOCKED && wake_reg != '0 && due) begin
                    state_next = SLOT_READY;
                    wake_next  = '0;
                end
            end
            OP_BLOCK: begin
                if (is_cur) begin
                    state_next = SLOT_BLOCKED;
                    wake_next  = block_wake;
                end
            end
            OP_RELEASE: begin
                if (is_cur && state_reg == SLOT_RUNNING) begin
                    state_next = SLOT_READY;
                end
            end
            OP_SELECT: begin
                if (cmd.sel == MY_IDX) begin
                    state_next = SLOT_RUNNING;
                end
            end
            default: begin
            end
        endcase
    end

    // round-robin distance from the slot after the current one
    always_comb begin
        if (MY_IDX > cmd.cur) begin
            gap_full = {1'b0, MY_IDX} - {1'b0, cmd.cur} - (SLOT_W+1)'(1);
        end else begin
            gap_full = {1'b0, MY_IDX} + (SLOT_W+1)'(MAX_TASKS)
                       - {1'b0, cmd.cur} - (SLOT_W+1)'(1);
        end
        gap = gap_full[SLOT_W-1:0];
    end

    assign eligible = (SLOT_IDX != 0) && in_use && state_reg == SLOT_READY
                      && prio != NO_PRIO;
    assign better   = !cand_in.found || prio < cand_in.prio
                      || (prio == cand_in.prio && gap < cand_in.gap);

    always_comb begin
        cand_next = cand_in;
        if (eligible && better) begin
            cand_next.found = 1'b1;
            cand_next.prio  = prio;
            cand_next.gap   = gap;
            cand_next.idx   = MY_IDX;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SLOT_READY;
            wake_reg  <= '0;
        end else begin
            state_reg <= state_next;
            wake_reg  <= wake_next;
        end
    end

    always_ff @(posedge aclk) begin
        cand_reg <= cand_next;
    end

    assign cand_out   = cand_reg;
    assign slot_ready = state_reg == SLOT_READY;

endmodule

// ===== hw/rtl/priority_round_robin_task_scheduler.sv =====
`timescale 1ns / 1ps
// Tick wakes due slots, delay blocks the current slot, yield releases it; then a scan
// and select, skipped with a single slot in use. An ignored delay or unused code goes
// straight to the result. The candidate wave crosses the slot cells one cell per cycle.
// One request at a time; the next can be taken once the result is registered.
// aresetn (synchronous): tick 0, idle slot current, all slots ready, no wakeups,
// slot count 1, priorities 0.
module priority_round_robin_task_scheduler #(
    parameter int MAX_TASKS  = 8,
    parameter int TICK_WIDTH = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_addr,
    input  logic [prrs_pkg::CFG_W-1:0]    cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [31:0]                   s_tdata,   // delay_ticks[31:0]
    input  logic [prrs_pkg::REQ_W-1:0]    s_tuser,   // req_type[1:0]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // running_task[2:0], tick_value[34:3], ready_mask[42:35], delay_ignored[43]
    output logic [47:0]                   m_tdata
);
    import prrs_pkg::*;

    localparam int IDX_W = $clog2(MAX_TASKS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WAKE,
        ST_BLOCK,
        ST_RELEASE,
        ST_SCAN,
        ST_SELECT,
        ST_FINISH
    } state_t;

    state_t                   state_reg, state_next;
    logic [COUNT_W-1:0]       slot_cfg_reg;
    logic [CFG_W-1:0]         task_prio_reg;
    logic [TICK_WIDTH-1:0]    counter_reg, counter_next;
    logic [IDX_W-1:0]         cur_reg, cur_next;
    logic [TICK_WIDTH-1:0]    block_wake_reg, block_wake_next;
    logic [IDX_W-1:0]         scan_cnt_reg, scan_cnt_next;
    logic                     ign_reg, ign_next;
    logic                     m_tvalid_reg, m_tvalid_next;
    logic [47:0]              m_tdata_reg, m_tdata_next;

    logic [COUNT_W-1:0]       n_slots;
    cell_cmd_t                cmd;
    cand_t                    cand [MAX_TASKS+1];
    logic [MAX_TASKS-1:0]     cell_ready;
    logic [MASK_W-1:0]        ready_mask;
    logic [IDX_W-1:0]         best;
    logic                     accept;

    // clamp the slot count into 1..MAX_TASKS
    always_comb begin
        if (slot_cfg_reg == '0) begin
            n_slots = COUNT_W'(1);
        end else if (slot_cfg_reg > COUNT_W'(MAX_TASKS)) begin
            n_slots = COUNT_W'(MAX_TASKS);
        end else begin
            n_slots = slot_cfg_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_cfg_reg  <= COUNT_W'(1);
            task_prio_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_TASK_COUNT: slot_cfg_reg  <= cfg_wdata[COUNT_W-1:0];
                REG_TASK_PRIO:  task_prio_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        cmd.op  = OP_NONE;
        cmd.cur = SLOT_W'(cur_reg);
        cmd.sel = SLOT_W'(best);
        cmd.n   = n_slots;
        unique case (state_reg)
            ST_WAKE:    cmd.op = OP_WAKE;
            ST_BLOCK:   cmd.op = OP_BLOCK;
            ST_RELEASE: cmd.op = OP_RELEASE;
            ST_SELECT:  cmd.op = OP_SELECT;
            default:    cmd.op = OP_NONE;
        endcase
    end

    assign cand[0] = '0;

    for (genvar g = 0; g < MAX_TASKS; g++) begin : g_cell
        prrs_cell #(
            .SLOT_IDX   (g),
            .MAX_TASKS  (MAX_TASKS),
            .TICK_WIDTH (TICK_WIDTH)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .cmd        (cmd),
            .counter    (counter_reg),
            .block_wake (block_wake_reg),
            .prio       (task_prio_reg[g*PRIO_W +: PRIO_W]),
            .cand_in    (cand[g]),
            .cand_out   (cand[g+1]),
            .slot_ready (cell_ready[g])
        );
    end

    // fall back to idle when no user task qualified
    assign best = cand[MAX_TASKS].found ? IDX_W'(cand[MAX_TASKS].idx) : '0;

    always_comb begin
        ready_mask = '0;
        for (int i = 0; i < MAX_TASKS; i++) begin
            ready_mask[i] = cell_ready[i] && (COUNT_W'(i) < n_slots);
        end
    end

    assign s_tready = state_reg == ST_IDLE;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next      = state_reg;
        counter_next    = counter_reg;
        cur_next        = cur_reg;
        block_wake_next = block_wake_reg;
        scan_cnt_next   = scan_cnt_reg;
        ign_next        = ign_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    ign_next        = 1'b0;
                    block_wake_next = counter_reg + TICK_WIDTH'(s_tdata);
                    case (s_tuser)
                        REQ_TICK: begin
                            counter_next = counter_reg + TICK_WIDTH'(1);
                            state_next   = ST_WAKE;
                        end
                        REQ_DELAY: begin
                            if (cur_reg != '0) begin
                                state_next = ST_BLOCK;
                            end else begin
                                ign_next   = 1'b1;
                                state_next = ST_FINISH;
                            end
                        end
                        REQ_YIELD: state_next = ST_RELEASE;
                        default:   state_next = ST_FINISH;
                    endcase
                end
            end
            ST_WAKE:  state_next = ST_RELEASE;
            ST_BLOCK: state_next = ST_RELEASE;
            ST_RELEASE: begin
                scan_cnt_next = '0;
                state_next    = (n_slots <= COUNT_W'(1)) ? ST_FINISH : ST_SCAN;
            end
            ST_SCAN: begin
                // wait for the candidate to reach the end of the chain
                scan_cnt_next = scan_cnt_reg + IDX_W'(1);
                if (scan_cnt_reg == IDX_W'(MAX_TASKS - 2)) begin
                    state_next = ST_SELECT;
                end
            end
            ST_SELECT: begin
                cur_next   = best;
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {4'b0, ign_reg, ready_mask,
                                     TICKO_W'(counter_reg), SLOT_W'(cur_reg)};
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            counter_reg    <= '0;
            cur_reg        <= '0;
            scan_cnt_reg   <= '0;
            ign_reg        <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            counter_reg    <= counter_next;
            cur_reg        <= cur_next;
            scan_cnt_reg   <= scan_cnt_next;
            ign_reg        <= ign_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
        block_wake_reg <= block_wake_next;
        m_tdata_reg    <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
